### design/rftd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rftd_pkg;

    localparam int STORE_DEPTH = 14;
    localparam int INDEX_W     = 4;
    localparam int CHAR_CNT_W  = 3;
    localparam int TAG_BITS    = 32;
    localparam int BCD_DIGITS  = 10;
    localparam int BCD_BITS    = 4 * BCD_DIGITS;
    localparam int STEP_CNT_W  = 5;

    localparam logic [INDEX_W-1:0] TAG_OFFSET = 4'd3;
    localparam logic [INDEX_W-1:0] INDEX_MAX  = 4'd15;
    localparam logic [INDEX_W-1:0] STORE_LAST = 4'd13;

    localparam logic [7:0] START_BYTE = 8'h02;
    localparam logic [7:0] END_BYTE   = 8'h03;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_t;

    // Decodes one ASCII character as a hex digit; only 0-9, a-f and A-F count.
    function automatic hex_t hex_digit(input logic [7:0] c);
        hex_t h;
        h.valid = 1'b1;
        h.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.value = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.value = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.value = 4'(c - 8'h37);
        end else begin
            h.valid = 1'b0;
        end
        return h;
    endfunction

endpackage

`default_nettype wire

### design/rfid_frame_tag_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

// RFID reader frame decoder.
// The slave channel takes one received serial byte per item on s_tdata. A start
// byte resets the frame position, and every byte at a position below STORE_DEPTH
// is stored in a small frame buffer. An end byte written at position FRAME_LEN - 1
// completes a frame: the hex tag characters at buffer offset three are decoded into
// a 32-bit tag, stopping at the first character that is not a hex digit, and that
// tag is converted into ten BCD digits. An end byte at any other position flags an
// error and clears the position. Every input item yields exactly one result item on
// the master channel, carrying the ok and error flags in m_tuser and the last tag in
// binary and BCD. A byte that completes no frame gives its result from the output
// register in the cycle after it is accepted. A completed frame passes through the
// parse state, which examines the tag characters in turn, the shift-and-add-3 unit,
// which converts the tag bit by bit, and then the output register. One item is in
// flight at a time; s_tready is low while a frame is being decoded or while an
// undelivered result waits. If the receiver stalls, the result holds in the output
// register and no new item is taken.
// Reset clears the frame position, the last tag (binary and BCD) and the output.
module rfid_frame_tag_decoder
    import rftd_pkg::*;
#(
    parameter int FRAME_LEN = 14,
    parameter int TAG_CHARS = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // [31:0] tag_value, [71:32] tag_decimal_bcd
    output logic [1:0]       m_tuser    // [0] frame_ok, [1] frame_error
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PARSE = 2'd1;
    localparam logic [1:0] ST_CONV  = 2'd2;

    logic [1:0]            state_reg;
    logic [INDEX_W-1:0]    index_reg;
    logic [CHAR_CNT_W-1:0] char_reg;
    logic [TAG_BITS-1:0]   acc_reg;
    logic [TAG_BITS-1:0]   last_tag_reg;
    logic [BCD_BITS-1:0]   last_bcd_reg;
    logic                  m_valid_reg;
    logic                  ok_reg;
    logic                  err_reg;
    logic [7:0]            store [STORE_DEPTH];

    logic                  s_fire;
    logic [INDEX_W-1:0]    idx_wr;
    logic [INDEX_W-1:0]    idx_inc;
    logic                  frame_good;
    hex_t                  digit;
    logic [TAG_BITS-1:0]   acc_shift;
    logic                  parse_last;
    logic                  conv_start;
    logic                  conv_done;
    logic [BCD_BITS-1:0]   conv_bcd;

    assign s_tready = (state_reg == ST_IDLE) && (!m_valid_reg || m_tready);
    assign s_fire   = s_tvalid && s_tready;

    // Position the byte is written to, and the position after it.
    assign idx_wr     = (s_tdata == START_BYTE) ? '0 : index_reg;
    assign idx_inc    = (idx_wr == INDEX_MAX) ? INDEX_MAX : idx_wr + 1'b1;
    assign frame_good = (idx_inc == INDEX_W'(FRAME_LEN));

    // One tag character is examined per cycle while parsing.
    assign digit      = hex_digit(store[TAG_OFFSET + INDEX_W'(char_reg)]);
    assign acc_shift  = {acc_reg[TAG_BITS-5:0], digit.value};
    assign parse_last = !digit.valid || (char_reg == CHAR_CNT_W'(TAG_CHARS - 1));
    assign conv_start = (state_reg == ST_PARSE) && parse_last;

    // The frame buffer has no reset; entries are only read after being written.
    always_ff @(posedge aclk) begin
        if (s_fire && idx_wr <= STORE_LAST) begin
            store[idx_wr] <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            index_reg    <= '0;
            last_tag_reg <= '0;
            last_bcd_reg <= '0;
            m_valid_reg  <= 1'b0;
            ok_reg       <= 1'b0;
            err_reg      <= 1'b0;
            char_reg     <= '0;
            acc_reg      <= '0;
        end else begin
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        if (s_tdata == END_BYTE && frame_good) begin
                            index_reg <= idx_inc;
                            char_reg  <= '0;
                            acc_reg   <= '0;
                            state_reg <= ST_PARSE;
                        end else begin
                            index_reg   <= (s_tdata == END_BYTE) ? '0 : idx_inc;
                            ok_reg      <= 1'b0;
                            err_reg     <= (s_tdata == END_BYTE);
                            m_valid_reg <= 1'b1;
                        end
                    end
                end
                ST_PARSE: begin
                    if (digit.valid) begin
                        acc_reg <= acc_shift;
                    end
                    char_reg <= char_reg + 1'b1;
                    if (parse_last) begin
                        last_tag_reg <= digit.valid ? acc_shift : acc_reg;
                        state_reg    <= ST_CONV;
                    end
                end
                ST_CONV: begin
                    if (conv_done) begin
                        last_bcd_reg <= conv_bcd;
                        ok_reg       <= 1'b1;
                        err_reg      <= 1'b0;
                        m_valid_reg  <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    rftd_bin2bcd u_bin2bcd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (conv_start),
        .bin_in  (digit.valid ? acc_shift : acc_reg),
        .done    (conv_done),
        .bcd_out (conv_bcd)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {last_bcd_reg, last_tag_reg};
    assign m_tuser  = {err_reg, ok_reg};

endmodule

`default_nettype wire

### design/rftd_bin2bcd.sv
`timescale 1ns / 1ps
`default_nettype none

// Shift-and-add-3 converter: one bit of the binary value per cycle.
module rftd_bin2bcd
    import rftd_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                start,
    input  wire logic [TAG_BITS-1:0] bin_in,
    output logic                     done,
    output logic [BCD_BITS-1:0]      bcd_out
);

    logic [TAG_BITS-1:0]   bin_reg;
    logic [BCD_BITS-1:0]   bcd_reg;
    logic [BCD_BITS-1:0]   bcd_adj;
    logic [STEP_CNT_W-1:0] step_reg;
    logic                  busy_reg;
    logic                  done_reg;

    always_comb begin
        for (int k = 0; k < BCD_DIGITS; k++) begin
            if (bcd_reg[4*k +: 4] >= 4'd5) begin
                bcd_adj[4*k +: 4] = bcd_reg[4*k +: 4] + 4'd3;
            end else begin
                bcd_adj[4*k +: 4] = bcd_reg[4*k +: 4];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
                bin_reg  <= bin_in;
                bcd_reg  <= '0;
            end else if (busy_reg) begin
                bcd_reg  <= {bcd_adj[BCD_BITS-2:0], bin_reg[TAG_BITS-1]};
                bin_reg  <= {bin_reg[TAG_BITS-2:0], 1'b0};
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_CNT_W'(TAG_BITS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done    = done_reg;
    assign bcd_out = bcd_reg;

endmodule

`default_nettype wire
